>>> sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher: operation codes,
// index limits, and the command and status bundles that connect the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned PERM_AW  = 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KEY_W-1:0]  key_t;

  // Operation codes carried by an input item.
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Index values that mark the end of the fill sweep and of the key schedule.
  localparam byte_t IDX_MAX    = 8'hFF;
  localparam byte_t IDX_PENULT = 8'hFE;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch data_byte and last_byte of the accepted item
    logic preset;     // i = 0xFF, j = 0 before the fill sweep
    logic step;       // i = i + 1, read S[i + 1]
    logic fill;       // write S[i + 1] = i + 1, i = i + 1
    logic fetch_j;    // a = read data, j = j + a (+ key byte), read S[j]
    logic key_mix;    // add the key byte into j during fetch_j
    logic swap_i;     // b = read data, write S[i] = b, read S[a + b]
    logic write_j;    // write S[j] = a
    logic load_out;   // load the result register
    logic clear_idx;  // i = 0, j = 0 at the end of the key schedule
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic i_is_max;     // index_i == 0xFF
    logic i_is_penult;  // index_i == 0xFE
  } dp_status_t;

endpackage

>>> sv/rc4_in_if.sv
// ----------------------------------------------------------------------------
// rc4_in_if
// Input channel of the RC4 cipher: valid/ready handshake with the operation
// code, the data byte and the last-of-buffer flag.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic          valid;
  logic          ready;
  logic          operation;
  rc4_pkg::byte_t data_byte;
  logic          last_byte;

  modport source (output valid, output operation, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input last_byte,
                  output ready);
endinterface

>>> sv/rc4_out_if.sv
// ----------------------------------------------------------------------------
// rc4_out_if
// Output channel of the RC4 cipher: valid/ready handshake with the ciphered
// byte and the passed-through last-of-buffer flag.
// ----------------------------------------------------------------------------
interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t result_byte;
  logic           result_last;

  modport source (output valid, output result_byte, output result_last, input ready);
  modport sink   (input valid, input result_byte, input result_last, output ready);
endinterface

>>> sv/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// RC4 datapath: key register, permutation memory, the two indices, the swap
// holding registers, keystream forwarding and the result register.
// ----------------------------------------------------------------------------
module rc4_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  rc4_pkg::key_t       cfg_wr_data,
  input  rc4_pkg::dp_cmd_t    cmd,
  output rc4_pkg::dp_status_t status,
  input  rc4_pkg::byte_t      data_byte,
  input  logic                last_byte,
  output rc4_pkg::byte_t      result_byte,
  output logic                result_last
);

  rc4_pkg::key_t  cipher_key;
  rc4_pkg::byte_t index_i;
  rc4_pkg::byte_t index_j;
  rc4_pkg::byte_t a_val;
  rc4_pkg::byte_t b_val;
  logic           hit_i;
  logic           hit_j;
  rc4_pkg::byte_t data_hold;
  logic           last_hold;
  rc4_pkg::byte_t rdata;
  rc4_pkg::byte_t perm_mem [2**rc4_pkg::PERM_AW];

  rc4_pkg::byte_t i_inc;
  rc4_pkg::byte_t key_byte;
  rc4_pkg::byte_t j_mix;
  rc4_pkg::byte_t ks_addr;
  rc4_pkg::byte_t keystream;
  rc4_pkg::byte_t raddr;
  rc4_pkg::byte_t waddr;
  rc4_pkg::byte_t wdata;
  logic           rd_en;
  logic           wr_en;

  // Key register, to be written by the user only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_wr_en) begin
      cipher_key <= cfg_wr_data;
    end
  end

  // Index arithmetic. The key byte is selected by the low three bits of i.
  assign i_inc    = index_i + 8'd1;
  assign key_byte = cipher_key[{index_i[2:0], 3'b000} +: rc4_pkg::BYTE_W];
  assign j_mix    = index_j + rdata + (cmd.key_mix ? key_byte : 8'd0);
  assign ks_addr  = a_val + rdata;

  // Read address selection.
  always_comb begin
    rd_en = cmd.step | cmd.fetch_j | cmd.swap_i;
    if (cmd.step) begin
      raddr = i_inc;
    end else if (cmd.fetch_j) begin
      raddr = j_mix;
    end else if (cmd.swap_i) begin
      raddr = ks_addr;
    end else begin
      raddr = index_i;
    end
  end

  // Write address and data selection; at most one write per cycle.
  always_comb begin
    wr_en = cmd.fill | cmd.swap_i | cmd.write_j;
    if (cmd.fill) begin
      waddr = i_inc;
      wdata = i_inc;
    end else if (cmd.swap_i) begin
      waddr = index_i;
      wdata = rdata;
    end else begin
      waddr = index_j;
      wdata = a_val;
    end
  end

  // Permutation memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= perm_mem[raddr];
    end
  end

  // Index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= '0;
      index_j <= '0;
    end else if (cmd.preset) begin
      index_i <= rc4_pkg::IDX_MAX;
      index_j <= '0;
    end else if (cmd.clear_idx) begin
      index_i <= '0;
      index_j <= '0;
    end else begin
      if (cmd.step || cmd.fill) begin
        index_i <= i_inc;
      end
      if (cmd.fetch_j) begin
        index_j <= j_mix;
      end
    end
  end

  // Swap operands. The keystream read overlaps the write of S[i], so the
  // address is compared against both swapped slots for forwarding.
  always_ff @(posedge clk) begin
    if (cmd.fetch_j) begin
      a_val <= rdata;
    end
    if (cmd.swap_i) begin
      b_val <= rdata;
      hit_i <= (ks_addr == index_i);
      hit_j <= (ks_addr == index_j);
    end
  end

  always_comb begin
    if (hit_i) begin
      keystream = b_val;
    end else if (hit_j) begin
      keystream = a_val;
    end else begin
      keystream = rdata;
    end
  end

  // Input holding and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_hold <= data_byte;
      last_hold <= last_byte;
    end
    if (cmd.load_out) begin
      result_byte <= data_hold ^ keystream;
      result_last <= last_hold;
    end
  end

  assign status.i_is_max    = (index_i == rc4_pkg::IDX_MAX);
  assign status.i_is_penult = (index_i == rc4_pkg::IDX_PENULT);

`ifndef ASSERT_OFF
  // The end of the key schedule leaves both indices at zero.
  a_clear_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_idx |=> (index_i == 8'd0 && index_j == 8'd0))
    else $error("indices not cleared after key schedule");

  // A step advances index_i by exactly one, wrapping at 256.
  a_step_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (index_i == $past(index_i) + 8'd1))
    else $error("index_i did not advance on step");
`endif

endmodule

>>> sv/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// RC4 controller: sequences the fill sweep and the key schedule for an
// initialize item, the swap and keystream lookup for a data item,
// and owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output rc4_pkg::dp_cmd_t    cmd,
  input  rc4_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_KSA_READ,
    S_READ_J,
    S_SWAP,
    S_FINISH
  } state_t;

  state_t state;
  logic   ksa_mode;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Datapath commands decoded from the current state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_op == rc4_pkg::OP_INIT) begin
            cmd.preset = 1'b1;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
      end
      S_KSA_READ: begin
        cmd.step = 1'b1;
      end
      S_READ_J: begin
        cmd.fetch_j = 1'b1;
        cmd.key_mix = ksa_mode;
      end
      S_SWAP: begin
        cmd.swap_i = 1'b1;
      end
      S_FINISH: begin
        cmd.write_j = 1'b1;
        if (ksa_mode) begin
          cmd.clear_idx = status.i_is_max;
        end else begin
          cmd.load_out = out_free;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State, mode and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ksa_mode  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == rc4_pkg::OP_INIT) begin
              state    <= S_FILL;
              ksa_mode <= 1'b1;
            end else begin
              state    <= S_READ_J;
              ksa_mode <= 1'b0;
            end
          end
        end
        S_FILL: begin
          if (status.i_is_penult) begin
            state <= S_KSA_READ;
          end
        end
        S_KSA_READ: begin
          state <= S_READ_J;
        end
        S_READ_J: begin
          state <= S_SWAP;
        end
        S_SWAP: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (ksa_mode) begin
            state <= status.i_is_max ? S_IDLE : S_KSA_READ;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted initialize item always starts the fill sweep.
  a_init_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == rc4_pkg::OP_INIT) |=> (state == S_FILL))
    else $error("initialize transfer did not start the fill sweep");

  // Loading the result register always presents a result.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  // The memory has one write port.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fill, cmd.swap_i, cmd.write_j}))
    else $error("more than one memory write in a cycle");
`endif

endmodule

>>> sv/rc4_keystream_cipher.sv
// An RC4 stream cipher with a 64-bit key taken least significant byte first
// from cfg_wr_data. An initialize transfer (operation 0) loads the identity
// permutation in a fill sweep, then runs the key schedule through S_KSA_READ,
// S_READ_J, S_SWAP and S_FINISH per step; it gives no result, and the next item
// is taken when it ends. A data transfer (operation 1) runs through the accept
// state, S_READ_J, S_SWAP and S_FINISH, set by the three dependent reads of the
// single-write permutation memory, whose registered read data feeds each next
// address. Its result byte is the input byte XOR the keystream byte, with the
// last flag passed through. A result waits in an output register, and the next
// item is accepted while it does. The key takes effect at the next initialize;
// data before the first initialize gives an undefined keystream.
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// Top level: joins the RC4 controller and datapath to the channel interfaces
// and the key configuration port.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  rc4_pkg::key_t cfg_wr_data,
  rc4_in_if.sink        in_ch,
  rc4_out_if.source     out_ch
);

  rc4_pkg::dp_cmd_t    cmd;
  rc4_pkg::dp_status_t status;

  // Sequencing and handshake control.
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.operation),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Permutation memory, indices and result path.
  rc4_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (in_ch.data_byte),
    .last_byte   (in_ch.last_byte),
    .result_byte (out_ch.result_byte),
    .result_last (out_ch.result_last)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RC4 keystream cipher. A queue of pending input
// transfers feeds a driver that works on the falling clock edge, and a monitor
// on the rising edge predicts every ciphered byte and checks each output
// transfer against the oldest prediction. The key register is changed only
// while the cipher is idle, across several phases with different key values
// and idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned KEY_BYTES     = rc4_pkg::KEY_W / rc4_pkg::BYTE_W;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned PHASE_ITEMS   = 145;
  localparam int unsigned SETTLE_CYCLES = 1500;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic           operation;
    rc4_pkg::byte_t data_byte;
    logic           last_byte;
  } cipher_item_t;

  typedef struct packed {
    rc4_pkg::byte_t result_byte;
    logic           result_last;
  } cipher_result_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_wr_en;
  rc4_pkg::key_t cfg_wr_data;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_keystream_cipher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Stimulus and expectation stores.
  cipher_item_t   pending_items[$];
  cipher_result_t expected_bytes[$];

  // Predicted cipher state and the key that the next schedule will use.
  rc4_pkg::byte_t sbox[PERM_DEPTH];
  rc4_pkg::byte_t idx_i;
  rc4_pkg::byte_t idx_j;
  rc4_pkg::key_t  active_key;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        in_took;
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned schedules_run;
  int unsigned bytes_checked;
  int unsigned failures;
  int unsigned cycle_count;

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit; a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still expected.",
               cycle_count, expected_bytes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Key schedule: identity fill, then 256 swaps with the key used cyclically.
  function void run_key_schedule();
    rc4_pkg::byte_t held;
    rc4_pkg::byte_t jj;
    jj = '0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      sbox[n] = rc4_pkg::byte_t'(n);
    end
    for (int n = 0; n < PERM_DEPTH; n++) begin
      held = sbox[n];
      jj = jj + active_key[rc4_pkg::BYTE_W*(n % KEY_BYTES) +: rc4_pkg::BYTE_W] + held;
      sbox[n] = sbox[jj];
      sbox[jj] = held;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // Advance the predicted state by one accepted transfer.
  function void predict_cipher(input cipher_item_t item);
    rc4_pkg::byte_t a;
    rc4_pkg::byte_t b;
    rc4_pkg::byte_t ks;
    cipher_result_t res;
    if (item.operation == rc4_pkg::OP_INIT) begin
      run_key_schedule();
      schedules_run++;
    end else begin
      idx_i = idx_i + 8'd1;
      a = sbox[idx_i];
      idx_j = idx_j + a;
      b = sbox[idx_j];
      sbox[idx_i] = b;
      sbox[idx_j] = a;
      ks = sbox[rc4_pkg::byte_t'(a + b)];
      res.result_byte = item.data_byte ^ ks;
      res.result_last = item.last_byte;
      expected_bytes.push_back(res);
    end
  endfunction

  // Driver: input transfers and output back-pressure change on the falling edge.
  always @(negedge clk) begin : drive_channels
    cipher_item_t nxt;
    if (!rst) begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_ch.valid || in_took) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.operation <= nxt.operation;
          in_ch.data_byte <= nxt.data_byte;
          in_ch.last_byte <= nxt.last_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer, then predicts from each input transfer.
  always @(posedge clk) begin : watch_channels
    cipher_result_t want;
    cipher_item_t   got_item;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("Output transfer with no byte expected: result_byte %02h", out_ch.result_byte);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_ch.result_byte !== want.result_byte) begin
            $error("result_byte: expected %02h, got %02h", want.result_byte, out_ch.result_byte);
            failures++;
          end
          if (out_ch.result_last !== want.result_last) begin
            $error("result_last: expected %0b, got %0b", want.result_last, out_ch.result_last);
            failures++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_item.operation = in_ch.operation;
        got_item.data_byte = in_ch.data_byte;
        got_item.last_byte = in_ch.last_byte;
        predict_cipher(got_item);
        items_taken++;
      end
    end
  end

  task automatic queue_item(input logic op, input rc4_pkg::byte_t data, input logic last);
    cipher_item_t item;
    item.operation = op;
    item.data_byte = data;
    item.last_byte = last;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic queue_random_data(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      queue_item(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom_range(255)),
                 ($urandom_range(3) == 0));
    end
  endtask

  // Wait until every transfer is taken and every byte has come out, then let
  // a key schedule that may still be running finish.
  task automatic wait_drained();
    while (items_taken != items_queued || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Key write, done only while the cipher is idle.
  task automatic load_key(input rc4_pkg::key_t k);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    active_key = k;
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    rc4_pkg::key_t phase_key;
    int unsigned   phase_start;
    int unsigned   seg_len;

    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = rc4_pkg::OP_INIT;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    in_took         = 1'b0;
    active_key      = '0;
    idx_i           = '0;
    idx_j           = '0;
    items_queued    = 0;
    items_taken     = 0;
    schedules_run   = 0;
    bytes_checked   = 0;
    failures        = 0;
    cycle_count     = 0;
    send_idle_pct   = 11;
    recv_idle_pct   = 55;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      // Idling pattern: light sender gaps first, then heavy, then none.
      if (phase < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 55;
      end else if (phase < 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase)
        0:       phase_key = '0;
        1:       phase_key = '1;
        4:       phase_key = 64'h0807_0605_0403_0201;
        default: phase_key = {$urandom, $urandom};
      endcase
      load_key(phase_key);
      phase_start = items_queued;

      if (phase == 0) begin
        // Directed part: the first transfer after reset must be an initialize.
        // Fields of an initialize are ignored, so give them odd values.
        queue_item(rc4_pkg::OP_INIT, 8'hFF, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        queue_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'h55, 1'b0);
        queue_item(rc4_pkg::OP_DATA, 8'hAA, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        // Back-to-back initialize transfers restart the same keystream.
        queue_item(rc4_pkg::OP_INIT, 8'h00, 1'b0);
        queue_item(rc4_pkg::OP_INIT, 8'hA5, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        queue_item(rc4_pkg::OP_DATA, 8'h01, 1'b1);
        queue_item(rc4_pkg::OP_DATA, 8'h80, 1'b0);
        queue_item(rc4_pkg::OP_DATA, 8'h7F, 1'b1);
      end else begin
        // The new key does not apply yet: keep ciphering with the old one.
        queue_random_data($urandom_range(3, 8));
      end

      // Random part: initialize followed by a run of data bytes; some runs
      // are long enough to wrap the byte indices.
      while (items_queued - phase_start < PHASE_ITEMS) begin
        queue_item(rc4_pkg::OP_INIT, rc4_pkg::byte_t'($urandom_range(255)),
                   logic'($urandom_range(1)));
        if ($urandom_range(11) == 0) begin
          seg_len = $urandom_range(260, 320);
        end else begin
          seg_len = $urandom_range(0, 30);
        end
        queue_random_data(seg_len);
      end

      wait_drained();
    end

    $display("Covered %0d input transfers in %0d phases:", items_taken, PHASE_COUNT);
    $display("%0d key schedules and %0d bytes checked.", schedules_run, bytes_checked);
    $display("Keys included all zeros and all ones; idling went from heavy to none.");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
